@@ rtl/crcbr_pkg.sv @@
// Shared types, constants and the CRC byte step for the bearing frame receiver.
// No dependencies; every other file in rtl/ depends on this package.

package crcbr_pkg;

    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 16;
    localparam int ANGLE_W = 16;
    localparam int FREQ_W  = 8;
    localparam int POS_W   = 4;

    // Depth of the queue between the frame front end and the result stage
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8005;

    // Byte positions within a 9-byte frame
    localparam logic [POS_W-1:0] POS_FIRST    = 4'd0;
    localparam logic [POS_W-1:0] POS_ANGLE_HI = 4'd2;
    localparam logic [POS_W-1:0] POS_ANGLE_LO = 4'd3;
    localparam logic [POS_W-1:0] POS_NEAR     = 4'd4;
    localparam logic [POS_W-1:0] POS_FREQ     = 4'd5;
    localparam logic [POS_W-1:0] POS_CRC_BYTES = 4'd7;
    localparam logic [POS_W-1:0] POS_CRC_HIGH = 4'd7;
    localparam logic [POS_W-1:0] POS_LAST     = 4'd8;

    localparam logic [BYTE_W-1:0] NEAR_CODE = 8'd1;

    // Summary of one completed frame, handed from the front end to the back end
    typedef struct packed {
        logic               crc_ok;
        logic [ANGLE_W-1:0] angle;
        logic               near;
        logic [FREQ_W-1:0]  freq;
    } frame_sum_t;

    // Shift one byte MSB first into the CRC register, no augmentation
    function automatic logic [CRC_W-1:0] crc_feed_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] r;
        logic             top;
        r = crc;
        for (int k = 0; k < BYTE_W; k++)
        begin
            top = r[CRC_W-1];
            r   = {r[CRC_W-2:0], data[BYTE_W-1-k]};
            if (top)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/crcbr_if.sv @@
// Valid/ready channel interfaces: received bytes in, frame results out.
// Depends on crcbr_pkg for field widths.

interface crcbr_byte_if;
    logic                           valid;
    logic                           ready;
    logic [crcbr_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcbr_result_if;
    logic                           valid;
    logic                           ready;
    logic                           crc_ok;
    logic [crcbr_pkg::ANGLE_W-1:0]  bearing_angle;
    logic                           source_near;
    logic [crcbr_pkg::FREQ_W-1:0]   ping_frequency;

    modport source (output valid, output crc_ok, output bearing_angle,
                    output source_near, output ping_frequency, input ready);
    modport sink   (input valid, input crc_ok, input bearing_angle,
                    input source_near, input ping_frequency, output ready);
endinterface

@@ rtl/crcbr_front.sv @@
// Front end: counts bytes into frames, runs the CRC and captures frame fields.
// Depends on crcbr_pkg and crcbr_if; pushes one summary per frame to the queue.

module crcbr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    crcbr_byte_if.sink            rx,
    input  logic                  q_full,
    output logic                  push,
    output crcbr_pkg::frame_sum_t push_data
);
    import crcbr_pkg::*;

    logic [POS_W-1:0]   pos_reg,        pos_next;
    logic [CRC_W-1:0]   crc_reg,        crc_next;
    logic [ANGLE_W-1:0] angle_reg,      angle_next;
    logic               near_reg,       near_next;
    logic [FREQ_W-1:0]  freq_reg,       freq_next;
    logic [BYTE_W-1:0]  crc_high_reg,   crc_high_next;

    logic [POS_W-1:0]   pos;
    logic               accept;
    logic               at_last;

    // Out-of-range count restarts a frame
    assign pos     = (pos_reg > POS_LAST) ? POS_FIRST : pos_reg;
    assign at_last = (pos == POS_LAST);

    // Stall only the frame-ending byte when the queue has no room
    assign rx.ready = !at_last || !q_full;
    assign accept   = rx.valid && rx.ready;
    assign push     = accept && at_last;

    assign push_data.crc_ok = (crc_reg == {crc_high_reg, rx.rx_byte});
    assign push_data.angle  = angle_reg;
    assign push_data.near   = near_reg;
    assign push_data.freq   = freq_reg;

    always_comb
    begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        angle_next    = angle_reg;
        near_next     = near_reg;
        freq_next     = freq_reg;
        crc_high_next = crc_high_reg;
        if (accept)
        begin
            if (pos < POS_CRC_BYTES)
            begin
                crc_next = crc_feed_byte(crc_reg, rx.rx_byte);
            end
            case (pos)
                POS_ANGLE_HI: angle_next    = {rx.rx_byte, angle_reg[BYTE_W-1:0]};
                POS_ANGLE_LO: angle_next    = {angle_reg[ANGLE_W-1:BYTE_W], rx.rx_byte};
                POS_NEAR:     near_next     = (rx.rx_byte == NEAR_CODE);
                POS_FREQ:     freq_next     = rx.rx_byte;
                POS_CRC_HIGH: crc_high_next = rx.rx_byte;
                default:      ;
            endcase
            if (at_last)
            begin
                pos_next = POS_FIRST;
                crc_next = '0;
            end
            else
            begin
                pos_next = pos + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_FIRST;
            crc_reg      <= '0;
            angle_reg    <= '0;
            near_reg     <= 1'b0;
            freq_reg     <= '0;
            crc_high_reg <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            angle_reg    <= angle_next;
            near_reg     <= near_next;
            freq_reg     <= freq_next;
            crc_high_reg <= crc_high_next;
        end
    end

`ifndef ASSERT_OFF
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (pos_reg == POS_FIRST) && (crc_reg == '0))
        else $error("front end did not restart after frame end");
`endif

endmodule

@@ rtl/crcbr_queue.sv @@
// Short queue of frame summaries between the front end and the result stage.
// Depends on crcbr_pkg for the summary type.

module crcbr_queue #(
    parameter int DEPTH = crcbr_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  crcbr_pkg::frame_sum_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output crcbr_pkg::frame_sum_t head
);
    import crcbr_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_sum_t        mem [DEPTH];
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("summary pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

@@ rtl/crcbr_back.sv @@
// Result stage: updates the held bearing values and drives the result register.
// Depends on crcbr_pkg and crcbr_if; pops frame summaries from the queue.

module crcbr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  crcbr_pkg::frame_sum_t head,
    output logic                  pop,
    crcbr_result_if.source        tx
);
    import crcbr_pkg::*;

    logic [ANGLE_W-1:0] held_angle_reg, held_angle_next;
    logic               held_near_reg,  held_near_next;
    logic [FREQ_W-1:0]  held_freq_reg,  held_freq_next;
    logic               out_valid_reg,  out_valid_next;
    logic               out_ok_reg;

    // Advance when the result register is empty or being taken
    assign pop = head_valid && (!out_valid_reg || tx.ready);

    always_comb
    begin
        held_angle_next = held_angle_reg;
        held_near_next  = held_near_reg;
        held_freq_next  = held_freq_reg;
        out_valid_next  = out_valid_reg && !tx.ready;
        if (pop)
        begin
            out_valid_next = 1'b1;
            if (head.crc_ok)
            begin
                held_angle_next = head.angle;
                held_near_next  = head.near;
                held_freq_next  = head.freq;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_angle_reg <= '0;
            held_near_reg  <= 1'b0;
            held_freq_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_angle_reg <= held_angle_next;
            held_near_reg  <= held_near_next;
            held_freq_reg  <= held_freq_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_ok_reg <= head.crc_ok;
        end
    end

    // Held values update only on pop, so they double as the result payload
    assign tx.valid          = out_valid_reg;
    assign tx.crc_ok         = out_ok_reg;
    assign tx.bearing_angle  = held_angle_reg;
    assign tx.source_near    = held_near_reg;
    assign tx.ping_frequency = held_freq_reg;

`ifndef ASSERT_OFF
    a_good_frame_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.crc_ok) |=> (held_angle_reg == $past(head.angle))
                                 && (held_freq_reg == $past(head.freq)))
        else $error("good frame did not update held values");
`endif

endmodule

@@ rtl/crc_checked_bearing_frame_receiver.sv @@
// Top level of the CRC-checked bearing frame receiver.
// Depends on crcbr_pkg, crcbr_if, crcbr_front, crcbr_queue and crcbr_back.
//
// Usage:
//   rx carries one received byte per transaction. Frames are 9 bytes, counted
//   from reset with no resynchronization: bytes 0-6 feed a CRC-16 (poly
//   0x8005, MSB first, zero start), bytes 7-8 hold the expected CRC, high
//   byte first. Bytes 2-3 are the angle, byte 4 the near code, byte 5 the
//   frequency.
//   tx carries one result transaction per frame: crc_ok plus the angle, near
//   flag and frequency of the last frame whose CRC matched.
// Throughput: one byte per cycle while rx is ready; the CRC step over a
//   whole byte is done in the front end in the cycle the byte is accepted.
// Path: the ninth byte's summary enters the queue at the accepting edge, then
//   moves into the result register when the result stage pops it.
// Stalls: while tx is held off, the queue absorbs finished frames; rx drops
//   ready only for a frame-ending byte when the queue is full.
// Reset: byte counter, CRC, held values and all valid state clear to zero;
//   the next byte after reset is byte 0 of a frame.

module crc_checked_bearing_frame_receiver #(
    parameter int QUEUE_DEPTH = crcbr_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    crcbr_byte_if.sink     rx,
    crcbr_result_if.source tx
);
    import crcbr_pkg::*;

    logic       q_full;
    logic       push;
    frame_sum_t push_data;
    logic       pop;
    logic       head_valid;
    frame_sum_t head;

    // Classify bytes and check the CRC
    crcbr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple byte intake from result delivery
    crcbr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Update held values and present results
    crcbr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .tx         (tx)
    );

endmodule
